// ----- sv/lofm_pkg.sv -----
// ----------------------------------------------------------------------------
// lofm_pkg
// Shared types and constants for the limit order fill matcher.
// ----------------------------------------------------------------------------
package lofm_pkg;

  // Order kinds
  localparam logic [1:0] KIND_LIMIT  = 2'd0;
  localparam logic [1:0] KIND_MARKET = 2'd1;
  localparam logic [1:0] KIND_NONE   = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  // Sides
  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  // Request types
  localparam logic REQ_NEW   = 1'b0;
  localparam logic REQ_QUOTE = 1'b1;

  // Result kinds
  localparam logic RES_FILL   = 1'b0;
  localparam logic RES_REJECT = 1'b1;

  // Configuration register indexes
  localparam logic CFG_SLIPPAGE = 1'b0;
  localparam logic CFG_RATIO    = 1'b1;

  // Fill ratio value meaning one in Q1.16
  localparam logic [16:0] RATIO_ONE = 17'h10000;

  // One pending order
  typedef struct packed {
    logic [31:0] cid;
    logic [31:0] xid;
    logic [31:0] ins;
    logic        side;
    logic [1:0]  kind;
    logic [30:0] price;
    logic [30:0] qty;
  } entry_t;

  // Per-cell control from the queue controller
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ----- sv/lofm_cell.sv -----
// ----------------------------------------------------------------------------
// lofm_cell
// One queue slot. Takes its upper neighbor on a shift, or a new entry on load.
// ----------------------------------------------------------------------------
module lofm_cell (
  input  logic              clk_i,
  input  lofm_pkg::cell_ctl_t ctl_i,
  input  lofm_pkg::entry_t  nbr_i,
  input  lofm_pkg::entry_t  load_i,
  output lofm_pkg::entry_t  data_o
);
  import lofm_pkg::*;

  entry_t data_q;

  // load wins over shift, otherwise hold
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      data_q <= load_i;
    end else if (ctl_i.shift) begin
      data_q <= nbr_i;
    end
  end

  assign data_o = data_q;

endmodule

// ----- sv/limit_order_fill_matcher.sv -----
// ----------------------------------------------------------------------------
// limit_order_fill_matcher
// Pending order queue built as a row of shifting cells, matched on quotes.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries a new order or a quote.
//   Output channel (out_valid_o / out_stall_i) carries fills and rejects.
//   A new order that fits is accepted and gives no beat. A new order on
//   a full queue gives one reject beat from the output register, and waits
//   at the input while that register still holds a stalled beat.
//   A valid quote scans the queue head first: each entry is evaluated with
//   the fill multiply, then the row of cells shifts and the entry, if kept,
//   is requeued at the tail. After the last entry an evaluate state closes
//   the scan and a flush state sends any final result, which the fill
//   pipeline holds back so it can carry last. Input is stalled during a
//   scan. A stalled output freezes the scan once a second result is
//   waiting. Reset empties the queue, sets the id counter that gives both
//   ids to one, slippage to zero and the fill ratio to one.
//   Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
// ----------------------------------------------------------------------------
module limit_order_fill_matcher #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic        side_i,
  input  logic [1:0]  order_kind_i,
  input  logic [30:0] limit_price_i,
  input  logic [30:0] order_qty_i,
  input  logic [31:0] instrument_i,
  input  logic [30:0] bid_price_i,
  input  logic [30:0] ask_price_i,
  input  logic        quote_valid_i,
  input  logic [63:0] quote_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [31:0] clord_id_o,
  output logic [31:0] exch_id_o,
  output logic [31:0] fill_instrument_o,
  output logic        fill_side_o,
  output logic [30:0] match_price_o,
  output logic [30:0] match_qty_o,
  output logic [30:0] leaves_qty_o,
  output logic [63:0] event_time_o,
  output logic        last_o
);
  import lofm_pkg::*;

  localparam int CntW = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_EVAL   = 2'd1;
  localparam logic [1:0] ST_COMMIT = 2'd2;
  localparam logic [1:0] ST_FLUSH  = 2'd3;

  typedef struct packed {
    logic        kind;
    logic [31:0] cid;
    logic [31:0] xid;
    logic [31:0] ins;
    logic        side;
    logic [30:0] price;
    logic [30:0] fqty;
    logic [30:0] rem;
    logic [63:0] etime;
  } res_t;

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] scan_q, scan_d;
  logic [31:0]     next_id_q, next_id_d;
  logic [15:0]     slip_q;
  logic [16:0]     ratio_q;
  logic [30:0]     bid_q, ask_q;
  logic [63:0]     qtime_q;
  logic [47:0]     prod_q;
  logic            fills_q;
  logic            pend_valid_q, pend_valid_d;
  res_t            pend_q;
  logic            out_valid_q, out_valid_d;
  res_t            out_q;
  logic            out_last_q;

  entry_t          cell_data [QUEUE_DEPTH];
  cell_ctl_t       cell_ctl  [QUEUE_DEPTH];
  entry_t          load_data;
  entry_t          head;

  logic in_acc, is_new, full, out_free;
  logic new_push, reject;
  logic [16:0] ratio_sat;
  logic [31:0] buy_lim, sell_lim;
  logic        fills_now;
  logic [30:0] fq, rem;
  logic        emit, keep, commit_go;

  assign head     = cell_data[0];
  assign full     = (count_q == CntW'(QUEUE_DEPTH));
  assign out_free = !out_valid_q || !out_stall_i;
  assign is_new   = (req_type_i == REQ_NEW);

  // stall while scanning, or a reject that cannot reach the output yet
  assign in_stall_o = (state_q != ST_IDLE) || (is_new && full && !out_free);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign new_push   = in_acc && is_new && !full;
  assign reject     = in_acc && is_new && full;

  // saturate ratio and form the match test for the head entry
  assign ratio_sat = (ratio_q > RATIO_ONE) ? RATIO_ONE : ratio_q;
  assign buy_lim   = {1'b0, head.price} + {16'd0, slip_q};
  assign sell_lim  = {1'b0, bid_q} + {16'd0, slip_q};
  always_comb begin
    case (head.kind)
      KIND_LIMIT:  fills_now = (head.side == SIDE_BUY) ? ({1'b0, ask_q} <= buy_lim)
                                                       : (sell_lim >= {1'b0, head.price});
      KIND_MARKET: fills_now = 1'b1;
      default:     fills_now = 1'b0;
    endcase
  end

  // fill quantity and remainder from the registered product
  assign fq        = prod_q[46:16];
  assign rem       = head.qty - fq;
  assign emit      = fills_q && (fq != 31'd0);
  // drop a filled entry that is used up or whose fill rounds to zero
  assign keep      = !fills_q || ((fq != 31'd0) && (rem != 31'd0));
  assign commit_go = !(emit && pend_valid_q && !out_free);

  // entry written into the row: new order or requeued head
  always_comb begin
    if (state_q == ST_COMMIT) begin
      load_data = head;
      if (fills_q) begin
        load_data.qty = rem;
      end
    end else begin
      load_data.cid   = next_id_q;
      load_data.xid   = next_id_q;
      load_data.ins   = instrument_i;
      load_data.side  = side_i;
      load_data.kind  = order_kind_i;
      load_data.price = limit_price_i;
      load_data.qty   = order_qty_i;
    end
  end

  // per-cell shift and load enables
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      cell_ctl[i].shift = (state_q == ST_COMMIT) && commit_go;
      cell_ctl[i].load  = (new_push && (count_q == CntW'(i))) ||
                          ((state_q == ST_COMMIT) && commit_go && keep &&
                           (count_q == CntW'(i + 1)));
    end
  end

  // row of cells
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    if (g == QUEUE_DEPTH - 1) begin : g_end
      lofm_cell u_cell (
        .clk_i (clk_i),
        .ctl_i (cell_ctl[g]),
        .nbr_i (cell_data[g]),
        .load_i(load_data),
        .data_o(cell_data[g])
      );
    end else begin : g_mid
      lofm_cell u_cell (
        .clk_i (clk_i),
        .ctl_i (cell_ctl[g]),
        .nbr_i (cell_data[g+1]),
        .load_i(load_data),
        .data_o(cell_data[g])
      );
    end
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    scan_d       = scan_q;
    next_id_d    = next_id_q;
    pend_valid_d = pend_valid_q;
    out_valid_d  = out_valid_q && out_stall_i;
    case (state_q)
      ST_IDLE: begin
        if (new_push) begin
          count_d   = count_q + CntW'(1);
          next_id_d = next_id_q + 32'd1;
        end else if (reject) begin
          out_valid_d = 1'b1;
        end else if (in_acc && quote_valid_i) begin
          scan_d  = count_q;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = (scan_q == '0) ? ST_FLUSH : ST_COMMIT;
      end
      ST_COMMIT: begin
        if (commit_go) begin
          count_d = count_q - CntW'(1) + CntW'(keep);
          scan_d  = scan_q - CntW'(1);
          state_d = ST_EVAL;
          if (emit) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
            end
            pend_valid_d = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_valid_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      count_q      <= '0;
      scan_q       <= '0;
      next_id_q    <= 32'd1;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      slip_q       <= '0;
      ratio_q      <= RATIO_ONE;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      scan_q       <= scan_d;
      next_id_q    <= next_id_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_SLIPPAGE: slip_q  <= cfg_wdata_i[15:0];
          CFG_RATIO:    ratio_q <= cfg_wdata_i;
          default:      ;
        endcase
      end
    end
  end

  // quote, product and result payload
  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_acc) begin
      bid_q   <= bid_price_i;
      ask_q   <= ask_price_i;
      qtime_q <= quote_time_i;
    end
    if (state_q == ST_EVAL) begin
      prod_q  <= {17'd0, head.qty} * {31'd0, ratio_sat};
      fills_q <= fills_now;
    end
    if (state_q == ST_COMMIT && commit_go && emit) begin
      pend_q.kind  <= RES_FILL;
      pend_q.cid   <= head.cid;
      pend_q.xid   <= head.xid;
      pend_q.ins   <= head.ins;
      pend_q.side  <= head.side;
      pend_q.price <= (head.side == SIDE_BUY) ? ask_q : bid_q;
      pend_q.fqty  <= fq;
      pend_q.rem   <= rem;
      pend_q.etime <= qtime_q;
      if (pend_valid_q) begin
        out_q      <= pend_q;
        out_last_q <= 1'b0;
      end
    end
    if (state_q == ST_FLUSH && pend_valid_q && out_free) begin
      out_q      <= pend_q;
      out_last_q <= 1'b1;
    end
    if (reject) begin
      out_q.kind  <= RES_REJECT;
      out_q.cid   <= '0;
      out_q.xid   <= '0;
      out_q.ins   <= instrument_i;
      out_q.side  <= side_i;
      out_q.price <= '0;
      out_q.fqty  <= '0;
      out_q.rem   <= order_qty_i;
      out_q.etime <= '0;
      out_last_q  <= 1'b1;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign result_kind_o     = out_q.kind;
  assign clord_id_o        = out_q.cid;
  assign exch_id_o         = out_q.xid;
  assign fill_instrument_o = out_q.ins;
  assign fill_side_o       = out_q.side;
  assign match_price_o     = out_q.price;
  assign match_qty_o       = out_q.fqty;
  assign leaves_qty_o      = out_q.rem;
  assign event_time_o      = out_q.etime;
  assign last_o            = out_last_q;

endmodule

// ----- sv/lofm_checker.sv -----
// ----------------------------------------------------------------------------
// lofm_checker
// Port-level checks for the limit order fill matcher.
// ----------------------------------------------------------------------------
module lofm_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        result_kind_o,
  input logic [30:0] match_qty_o,
  input logic [31:0] clord_id_o,
  input logic        last_o
);
  import lofm_pkg::*;

  // hold a stalled beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(clord_id_o))
    else $error("stalled output beat changed");

  // a reject is always the final beat
  a_rej_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_REJECT |-> last_o)
    else $error("reject without last");

  // a fill never carries zero quantity
  a_fill_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == RES_FILL |-> match_qty_o != 31'd0)
    else $error("fill with zero quantity");

endmodule

bind limit_order_fill_matcher lofm_checker u_lofm_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .result_kind_o(result_kind_o),
  .match_qty_o  (match_qty_o),
  .clord_id_o   (clord_id_o),
  .last_o       (last_o)
);
